@@ hdl/assert_macros.svh @@
// Shared assertion macros for the watchdog checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nlw_pkg.sv @@
package nlw_pkg;

    localparam int TIMER_W_DEF = 14;
    localparam int DEPTH_W_DEF = 8;

    localparam int TO_W    = 14;
    localparam int CODE_W  = 8;
    localparam int STAMP_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [STAMP_W-1:0] STAMP_MAGIC = 32'h5349_5300;
    localparam logic [STAMP_W-CODE_W-1:0] MAGIC_HIGH = STAMP_MAGIC[STAMP_W-1:CODE_W];

    localparam logic [TO_W-1:0]   MAIN_TO_RST    = 14'd8000;
    localparam logic [TO_W-1:0]   FLASH_TO_RST   = 14'd2000;
    localparam logic [CODE_W-1:0] PHASE_LIM_RST  = 8'd8;
    localparam logic [CODE_W-1:0] BOOT_CODE_RST  = 8'd1;
    localparam logic [CODE_W-1:0] MAIN_CODE_RST  = 8'd2;
    localparam logic [CODE_W-1:0] FLASH_CODE_RST = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_TO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_CODE = 3'd5;

    typedef enum logic [2:0] {
        REQ_TICK        = 3'd0,
        REQ_BOOT        = 3'd1,
        REQ_START       = 3'd2,
        REQ_NOTE        = 3'd3,
        REQ_FEED        = 3'd4,
        REQ_FLASH_BEGIN = 3'd5,
        REQ_CHECKPOINT  = 3'd6,
        REQ_FLASH_END   = 3'd7
    } req_t;

    typedef struct packed {
        logic [TO_W-1:0]   main_timeout;
        logic [TO_W-1:0]   flash_timeout;
        logic [CODE_W-1:0] phase_limit;
        logic [CODE_W-1:0] boot_code;
        logic [CODE_W-1:0] main_code;
        logic [CODE_W-1:0] flash_code;
    } cfg_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp_now;
        logic               is_started;
        logic [CODE_W-1:0]  lease_depth;
        logic               is_armed;
        logic               expired;
        logic               ev_timeout_reset;
        logic               ev_phase_valid;
        logic [CODE_W-1:0]  ev_phase;
        logic [STAMP_W-1:0] ev_raw_stamp;
    } res_t;

    function automatic logic code_ok(input logic [CODE_W-1:0] code,
                                     input logic [CODE_W-1:0] limit);
        return (code != '0) && (code < limit);
    endfunction

    function automatic logic [STAMP_W-1:0] stamp_of(input logic [CODE_W-1:0] code,
                                                    input logic [CODE_W-1:0] limit);
        return STAMP_MAGIC | {{(STAMP_W-CODE_W){1'b0}},
                              (code_ok(code, limit) ? code : {CODE_W{1'b0}})};
    endfunction

endpackage

@@ hdl/nested_lease_watchdog_core.sv @@
// Watchdog with phase stamps and nested flash leases. The state registers
// update at the edge that accepts an event word, and the result word is
// registered into the output buffer at that same edge, so a new event can
// be accepted every cycle while in_stall is low. A two-word output buffer
// absorbs downstream stalls; in_stall rises only when both of its entries
// are occupied. Configuration writes are taken in any cycle and are always
// ready.
module nested_lease_watchdog_core #(
    parameter int TIMER_WIDTH = nlw_pkg::TIMER_W_DEF,
    parameter int DEPTH_WIDTH = nlw_pkg::DEPTH_W_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     req_type,
    input  logic [nlw_pkg::CODE_W-1:0]     phase,
    input  logic                           reboot_by_watchdog,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [nlw_pkg::STAMP_W-1:0]    stamp_now,
    output logic                           is_started,
    output logic [nlw_pkg::CODE_W-1:0]     lease_depth,
    output logic                           is_armed,
    output logic                           expired,
    output logic                           ev_timeout_reset,
    output logic                           ev_phase_valid,
    output logic [nlw_pkg::CODE_W-1:0]     ev_phase,
    output logic [nlw_pkg::STAMP_W-1:0]    ev_raw_stamp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nlw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nlw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nlw_pkg::*;

    cfg_t cfg_reg;
    res_t res;
    res_t out_data;
    logic accept;
    logic buf_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.main_timeout  <= MAIN_TO_RST;
            cfg_reg.flash_timeout <= FLASH_TO_RST;
            cfg_reg.phase_limit   <= PHASE_LIM_RST;
            cfg_reg.boot_code     <= BOOT_CODE_RST;
            cfg_reg.main_code     <= MAIN_CODE_RST;
            cfg_reg.flash_code    <= FLASH_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAIN_TO:    cfg_reg.main_timeout  <= cfg_data[TO_W-1:0];
                CFG_FLASH_TO:   cfg_reg.flash_timeout <= cfg_data[TO_W-1:0];
                CFG_PHASE_LIM:  cfg_reg.phase_limit   <= cfg_data[CODE_W-1:0];
                CFG_BOOT_CODE:  cfg_reg.boot_code     <= cfg_data[CODE_W-1:0];
                CFG_MAIN_CODE:  cfg_reg.main_code     <= cfg_data[CODE_W-1:0];
                CFG_FLASH_CODE: cfg_reg.flash_code    <= cfg_data[CODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    nlw_engine #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .req_type           (req_type),
        .phase              (phase),
        .reboot_by_watchdog (reboot_by_watchdog),
        .cfg                (cfg_reg),
        .res                (res)
    );

    nlw_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign stamp_now        = out_data.stamp_now;
    assign is_started       = out_data.is_started;
    assign lease_depth      = out_data.lease_depth;
    assign is_armed         = out_data.is_armed;
    assign expired          = out_data.expired;
    assign ev_timeout_reset = out_data.ev_timeout_reset;
    assign ev_phase_valid   = out_data.ev_phase_valid;
    assign ev_phase         = out_data.ev_phase;
    assign ev_raw_stamp     = out_data.ev_raw_stamp;

endmodule

@@ hdl/nlw_engine.sv @@
module nlw_engine #(
    parameter int TIMER_WIDTH = nlw_pkg::TIMER_W_DEF,
    parameter int DEPTH_WIDTH = nlw_pkg::DEPTH_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [2:0]                  req_type,
    input  logic [nlw_pkg::CODE_W-1:0]  phase,
    input  logic                        reboot_by_watchdog,
    input  nlw_pkg::cfg_t               cfg,
    output nlw_pkg::res_t               res
);
    import nlw_pkg::*;

    localparam int TEXT_W = (TIMER_WIDTH > TO_W) ? TIMER_WIDTH : TO_W;
    localparam int DEXT_W = (DEPTH_WIDTH > CODE_W) ? DEPTH_WIDTH : CODE_W;

    logic                   captured_reg, captured_next;
    logic                   started_reg, started_next;
    logic                   armed_reg, armed_next;
    logic [DEPTH_WIDTH-1:0] depth_reg, depth_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic                   cap_timeout_reg, cap_timeout_next;
    logic                   cap_valid_reg, cap_valid_next;
    logic [CODE_W-1:0]      cap_phase_reg, cap_phase_next;
    logic [STAMP_W-1:0]     cap_stamp_reg, cap_stamp_next;
    logic                   expired;

    logic [TEXT_W-1:0]      main_ext, flash_ext;
    logic [TIMER_WIDTH-1:0] main_ld, flash_ld;
    logic [DEXT_W-1:0]      depth_ext;
    logic [CODE_W-1:0]      old_code;
    req_t                   req;

    assign main_ext  = TEXT_W'(cfg.main_timeout);
    assign flash_ext = TEXT_W'(cfg.flash_timeout);
    assign main_ld   = main_ext[TIMER_WIDTH-1:0];
    assign flash_ld  = flash_ext[TIMER_WIDTH-1:0];
    assign old_code  = stamp_reg[CODE_W-1:0];
    assign req       = req_t'(req_type);

    always_comb
    begin
        captured_next    = captured_reg;
        started_next     = started_reg;
        armed_next       = armed_reg;
        depth_next       = depth_reg;
        stamp_next       = stamp_reg;
        count_next       = count_reg;
        cap_timeout_next = cap_timeout_reg;
        cap_valid_next   = cap_valid_reg;
        cap_phase_next   = cap_phase_reg;
        cap_stamp_next   = cap_stamp_reg;
        expired          = 1'b0;

        // Boot capture runs only once, and start performs it first if needed.
        if (!captured_reg && (req == REQ_BOOT || req == REQ_START))
        begin
            cap_stamp_next   = stamp_reg;
            cap_timeout_next = reboot_by_watchdog;
            cap_valid_next   = reboot_by_watchdog
                               && (stamp_reg[STAMP_W-1:CODE_W] == MAGIC_HIGH)
                               && code_ok(old_code, cfg.phase_limit);
            cap_phase_next   = cap_valid_next ? old_code : '0;
            armed_next       = 1'b0;
            started_next     = 1'b0;
            depth_next       = '0;
            captured_next    = 1'b1;
        end

        case (req)
            REQ_TICK:
            begin
                if (armed_reg)
                begin
                    if (count_reg <= TIMER_WIDTH'(1))
                    begin
                        count_next = '0;
                        armed_next = 1'b0;
                        expired    = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - TIMER_WIDTH'(1);
                    end
                end
            end
            REQ_BOOT:
            begin
            end
            REQ_START:
            begin
                if (!started_next)
                begin
                    stamp_next   = stamp_of(cfg.boot_code, cfg.phase_limit);
                    count_next   = main_ld;
                    armed_next   = 1'b1;
                    started_next = 1'b1;
                end
            end
            REQ_NOTE:
            begin
                if (started_reg && depth_reg == '0)
                begin
                    stamp_next = stamp_of(phase, cfg.phase_limit);
                end
            end
            REQ_FEED:
            begin
                if (started_reg && depth_reg == '0)
                begin
                    stamp_next = stamp_of(phase, cfg.phase_limit);
                    count_next = main_ld;
                end
            end
            REQ_FLASH_BEGIN:
            begin
                stamp_next = stamp_of(cfg.flash_code, cfg.phase_limit);
                count_next = flash_ld;
                if (depth_reg != '0)
                begin
                    if (depth_reg != '1)
                    begin
                        depth_next = depth_reg + DEPTH_WIDTH'(1);
                    end
                end
                else
                begin
                    depth_next = DEPTH_WIDTH'(1);
                    armed_next = 1'b1;
                end
            end
            REQ_CHECKPOINT:
            begin
                if (depth_reg != '0)
                begin
                    stamp_next = stamp_of(cfg.flash_code, cfg.phase_limit);
                    count_next = flash_ld;
                end
            end
            REQ_FLASH_END:
            begin
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - DEPTH_WIDTH'(1);
                    if (depth_next != '0)
                    begin
                        stamp_next = stamp_of(cfg.flash_code, cfg.phase_limit);
                        count_next = flash_ld;
                    end
                    else if (started_reg)
                    begin
                        stamp_next = stamp_of(cfg.main_code, cfg.phase_limit);
                        count_next = main_ld;
                        armed_next = 1'b1;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign depth_ext = DEXT_W'(depth_next);

    always_comb
    begin
        res.stamp_now        = stamp_next;
        res.is_started       = started_next;
        res.lease_depth      = depth_ext[CODE_W-1:0];
        res.is_armed         = armed_next;
        res.expired          = expired;
        res.ev_timeout_reset = cap_timeout_next;
        res.ev_phase_valid   = cap_valid_next;
        res.ev_phase         = cap_phase_next;
        res.ev_raw_stamp     = cap_stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            captured_reg    <= 1'b0;
            started_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            depth_reg       <= '0;
            stamp_reg       <= '0;
            count_reg       <= '0;
            cap_timeout_reg <= 1'b0;
            cap_valid_reg   <= 1'b0;
            cap_phase_reg   <= '0;
            cap_stamp_reg   <= '0;
        end
        else if (accept)
        begin
            captured_reg    <= captured_next;
            started_reg     <= started_next;
            armed_reg       <= armed_next;
            depth_reg       <= depth_next;
            stamp_reg       <= stamp_next;
            count_reg       <= count_next;
            cap_timeout_reg <= cap_timeout_next;
            cap_valid_reg   <= cap_valid_next;
            cap_phase_reg   <= cap_phase_next;
            cap_stamp_reg   <= cap_stamp_next;
        end
    end

endmodule

@@ hdl/nlw_outbuf.sv @@
module nlw_outbuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nlw_pkg::res_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_stall,
    output nlw_pkg::res_t out_data
);
    import nlw_pkg::*;

    logic head_valid_reg;
    logic skid_valid_reg;
    res_t head_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = head_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                head_reg <= push_data;
            end
        end
    end

endmodule

@@ hdl/nlw_chk.sv @@
`include "assert_macros.svh"

module nlw_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [nlw_pkg::STAMP_W-1:0] stamp_now,
    input logic [nlw_pkg::CODE_W-1:0]  lease_depth,
    input logic                        is_armed,
    input logic                        expired,
    input logic                        ev_timeout_reset,
    input logic                        ev_phase_valid,
    input logic [nlw_pkg::CODE_W-1:0]  ev_phase
);
    import nlw_pkg::*;

    `NLW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "Stalled word was dropped.")
    `NLW_ASSERT_NOW(a_expire_disarms, clk, rst_n, out_valid && expired, !is_armed, "Expiry left the countdown armed.")
    `NLW_ASSERT_NOW(a_lease_magic, clk, rst_n, out_valid && lease_depth != '0, stamp_now[STAMP_W-1:CODE_W] == MAGIC_HIGH, "Held lease without magic in the stamp.")
    `NLW_ASSERT_NOW(a_valid_needs_timeout, clk, rst_n, out_valid && ev_phase_valid, ev_timeout_reset, "Valid evidence without a watchdog reboot.")
    `NLW_ASSERT_NOW(a_invalid_phase_zero, clk, rst_n, out_valid && !ev_phase_valid, ev_phase == '0, "Captured phase is nonzero without valid evidence.")

endmodule

bind nested_lease_watchdog_core nlw_chk u_nlw_chk (.*);

@@ tb/tb_nested_lease_watchdog_core.sv @@
`timescale 1ns / 100ps

module tb_nested_lease_watchdog_core;
    import nlw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_CAP  = 30;

    class watchdog_tracker;
        logic [TO_W-1:0]    main_to;
        logic [TO_W-1:0]    flash_to;
        logic [TO_W-1:0]    count;
        logic [CODE_W-1:0]  limit;
        logic [CODE_W-1:0]  boot_cd;
        logic [CODE_W-1:0]  main_cd;
        logic [CODE_W-1:0]  flash_cd;
        logic [CODE_W-1:0]  depth;
        logic [CODE_W-1:0]  peak_depth;
        logic [CODE_W-1:0]  cap_ph;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] cap_st;
        bit                 captured;
        bit                 started;
        bit                 armed;
        bit                 cap_to;
        bit                 cap_ok;
        res_t               expected_q[$];
        int                 fails;
        int                 checked;
        int                 events;
        int                 effective;
        int                 expiries;

        function new();
            main_to    = MAIN_TO_RST;
            flash_to   = FLASH_TO_RST;
            limit      = PHASE_LIM_RST;
            boot_cd    = BOOT_CODE_RST;
            main_cd    = MAIN_CODE_RST;
            flash_cd   = FLASH_CODE_RST;
            count      = '0;
            depth      = '0;
            peak_depth = '0;
            cap_ph     = '0;
            stamp      = '0;
            cap_st     = '0;
            captured   = 1'b0;
            started    = 1'b0;
            armed      = 1'b0;
            cap_to     = 1'b0;
            cap_ok     = 1'b0;
            fails      = 0;
            checked    = 0;
            events     = 0;
            effective  = 0;
            expiries   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAIN_TO:    main_to  = data;
                CFG_FLASH_TO:   flash_to = data;
                CFG_PHASE_LIM:  limit    = data[CODE_W-1:0];
                CFG_BOOT_CODE:  boot_cd  = data[CODE_W-1:0];
                CFG_MAIN_CODE:  main_cd  = data[CODE_W-1:0];
                CFG_FLASH_CODE: flash_cd = data[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit code_valid(logic [CODE_W-1:0] code);
            return (code != '0) && (code < limit);
        endfunction

        function void publish(logic [CODE_W-1:0] code);
            stamp = STAMP_MAGIC | STAMP_W'(code_valid(code) ? code : '0);
        endfunction

        function void capture(bit by_watchdog);
            if (captured)
                return;
            cap_st   = stamp;
            cap_to   = by_watchdog;
            cap_ok   = by_watchdog && (stamp[STAMP_W-1:CODE_W] == MAGIC_HIGH)
                       && code_valid(stamp[CODE_W-1:0]);
            cap_ph   = cap_ok ? stamp[CODE_W-1:0] : '0;
            armed    = 1'b0;
            started  = 1'b0;
            depth    = '0;
            captured = 1'b1;
        endfunction

        function res_t status(bit fired);
            res_t view;
            view.stamp_now        = stamp;
            view.is_started       = started;
            view.lease_depth      = depth;
            view.is_armed         = armed;
            view.expired          = fired;
            view.ev_timeout_reset = cap_to;
            view.ev_phase_valid   = cap_ok;
            view.ev_phase         = cap_ph;
            view.ev_raw_stamp     = cap_st;
            return view;
        endfunction

        function void note_event(req_t req, logic [CODE_W-1:0] ph, bit by_watchdog);
            res_t            prior;
            res_t            after;
            logic [TO_W-1:0] prior_count;
            bit              prior_captured;
            bit              fired;
            prior          = status(1'b0);
            prior_count    = count;
            prior_captured = captured;
            fired          = 1'b0;
            case (req)
                REQ_TICK:
                begin
                    if (armed)
                    begin
                        if (count <= 1)
                        begin
                            count = '0;
                            armed = 1'b0;
                            fired = 1'b1;
                        end
                        else
                        begin
                            count = count - 1'b1;
                        end
                    end
                end
                REQ_BOOT:
                begin
                    capture(by_watchdog);
                end
                REQ_START:
                begin
                    capture(by_watchdog);
                    if (!started)
                    begin
                        publish(boot_cd);
                        count   = main_to;
                        armed   = 1'b1;
                        started = 1'b1;
                    end
                end
                REQ_NOTE:
                begin
                    if (started && depth == '0)
                        publish(ph);
                end
                REQ_FEED:
                begin
                    if (started && depth == '0)
                    begin
                        publish(ph);
                        count = main_to;
                    end
                end
                REQ_FLASH_BEGIN:
                begin
                    if (depth != '0)
                    begin
                        if (depth != '1)
                            depth = depth + 1'b1;
                    end
                    else
                    begin
                        depth = 1;
                        armed = 1'b1;
                    end
                    publish(flash_cd);
                    count = flash_to;
                end
                REQ_CHECKPOINT:
                begin
                    if (depth != '0)
                    begin
                        publish(flash_cd);
                        count = flash_to;
                    end
                end
                REQ_FLASH_END:
                begin
                    if (depth != '0)
                    begin
                        depth = depth - 1'b1;
                        if (depth != '0)
                        begin
                            publish(flash_cd);
                            count = flash_to;
                        end
                        else if (started)
                        begin
                            publish(main_cd);
                            count = main_to;
                            armed = 1'b1;
                        end
                        else
                        begin
                            armed = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            after = status(fired);
            expected_q.push_back(after);
            events++;
            if (fired)
                expiries++;
            if (depth > peak_depth)
                peak_depth = depth;
            if (after != prior || count != prior_count || captured != prior_captured)
                effective++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                fails++;
                if (fails <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_status(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_CAP)
                    $display("%0t: status word arrived with nothing expected, actual %0h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("stamp_now", want.stamp_now, got.stamp_now);
            compare_field("is_started", want.is_started, got.is_started);
            compare_field("lease_depth", want.lease_depth, got.lease_depth);
            compare_field("is_armed", want.is_armed, got.is_armed);
            compare_field("expired", want.expired, got.expired);
            compare_field("ev_timeout_reset", want.ev_timeout_reset, got.ev_timeout_reset);
            compare_field("ev_phase_valid", want.ev_phase_valid, got.ev_phase_valid);
            compare_field("ev_phase", want.ev_phase, got.ev_phase);
            compare_field("ev_raw_stamp", want.ev_raw_stamp, got.ev_raw_stamp);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [2:0]            req_type;
    logic [CODE_W-1:0]     phase;
    logic                  reboot_by_watchdog;
    logic                  out_valid;
    logic                  out_stall;
    logic [STAMP_W-1:0]    stamp_now;
    logic                  is_started;
    logic [CODE_W-1:0]     lease_depth;
    logic                  is_armed;
    logic                  expired;
    logic                  ev_timeout_reset;
    logic                  ev_phase_valid;
    logic [CODE_W-1:0]     ev_phase;
    logic [STAMP_W-1:0]    ev_raw_stamp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    watchdog_tracker tracker;
    bit              quiet = 1'b0;
    int              stall_left = 0;
    int              cycle_count = 0;
    int              settings = 1;

    nested_lease_watchdog_core DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .req_type           (req_type),
        .phase              (phase),
        .reboot_by_watchdog (reboot_by_watchdog),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .stamp_now          (stamp_now),
        .is_started         (is_started),
        .lease_depth        (lease_depth),
        .is_armed           (is_armed),
        .expired            (expired),
        .ev_timeout_reset   (ev_timeout_reset),
        .ev_phase_valid     (ev_phase_valid),
        .ev_phase           (ev_phase),
        .ev_raw_stamp       (ev_raw_stamp),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [CODE_W-1:0] pick_phase();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2: return tracker.limit;
            3: return tracker.limit - 1'b1;
            4: return CODE_W'($urandom_range(0, tracker.limit));
            default: return CODE_W'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin : out_pacing
            int g;
            g = idle_gap();
            out_stall  <= (g > 0);
            stall_left <= (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin : observe
            res_t seen;
            seen = {stamp_now, is_started, lease_depth, is_armed, expired,
                    ev_timeout_reset, ev_phase_valid, ev_phase, ev_raw_stamp};
            if (cfg_valid && cfg_ready)
                tracker.write_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                tracker.check_status(seen);
            if (in_valid && !in_stall)
                tracker.note_event(req_t'(req_type), phase, reboot_by_watchdog);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d status words outstanding",
                     $time, tracker.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_event(input req_t req, input logic [CODE_W-1:0] ph, input logic wd);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        req_type           <= req;
        phase              <= ph;
        reboot_by_watchdog <= wd;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic tick_burst(input int n);
        repeat (n) send_event(REQ_TICK, CODE_W'($urandom), rbit());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_registers(input int main_ticks, input int flash_ticks, input int lim,
                                 input int boot_c, input int main_c, input int flash_c);
        settle();
        write_word(CFG_MAIN_TO, main_ticks);
        write_word(CFG_FLASH_TO, flash_ticks);
        write_word(CFG_PHASE_LIM, lim);
        write_word(CFG_BOOT_CODE, boot_c);
        write_word(CFG_MAIN_CODE, main_c);
        write_word(CFG_FLASH_CODE, flash_c);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic lease_sequence();
        int k;
        int closes;
        int r;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
        begin
            send_event(REQ_FLASH_BEGIN, CODE_W'($urandom), rbit());
            if ($urandom_range(0, 2) == 0)
                send_event(REQ_CHECKPOINT, CODE_W'($urandom), rbit());
            tick_burst($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                send_event(rbit() ? REQ_FEED : REQ_NOTE, pick_phase(), rbit());
        end
        r = $urandom_range(0, 9);
        closes = (r == 0) ? k - 1 : (r == 1) ? k + 1 : k;
        for (int i = 0; i < closes; i++)
        begin
            send_event(REQ_FLASH_END, CODE_W'($urandom), rbit());
            tick_burst($urandom_range(0, 2));
        end
    endtask

    task automatic running_sequence();
        int n;
        int reach;
        n = $urandom_range(1, 4);
        reach = (tracker.main_to <= 20) ? int'(tracker.main_to) + 1 : 6;
        for (int i = 0; i < n; i++)
        begin
            send_event(rbit() ? REQ_FEED : REQ_NOTE, pick_phase(), rbit());
            tick_burst($urandom_range(0, reach));
        end
    endtask

    task automatic run_random(input int target);
        int first;
        int r;
        first = tracker.effective;
        while (tracker.effective - first < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                lease_sequence();
            else if (r < 65)
                running_sequence();
            else if (r < 80)
                tick_burst($urandom_range(1, 20));
            else
                send_event(req_t'($urandom_range(0, 7)), CODE_W'($urandom), rbit());
        end
    endtask

    task automatic deep_nesting();
        repeat (258) send_event(REQ_FLASH_BEGIN, CODE_W'($urandom), rbit());
        send_event(REQ_CHECKPOINT, CODE_W'($urandom), rbit());
        send_event(REQ_CHECKPOINT, CODE_W'($urandom), rbit());
        tick_burst(1);
        repeat (258) send_event(REQ_FLASH_END, CODE_W'($urandom), rbit());
    endtask

    initial
    begin
        tracker            = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        req_type           = REQ_TICK;
        phase              = '0;
        reboot_by_watchdog = 1'b0;
        out_stall          = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_MAIN_TO;
        cfg_data           = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Leases taken before boot capture leave a valid stamp for the capture to decode.
        send_event(REQ_TICK, 8'h00, 1'b0);
        send_event(REQ_NOTE, 8'h05, 1'b1);
        send_event(REQ_FEED, 8'hff, 1'b0);
        send_event(REQ_FLASH_END, 8'h00, 1'b1);
        send_event(REQ_CHECKPOINT, 8'h00, 1'b0);
        send_event(REQ_FLASH_BEGIN, 8'haa, 1'b0);
        send_event(REQ_FLASH_BEGIN, 8'h55, 1'b1);
        send_event(REQ_CHECKPOINT, 8'h00, 1'b0);
        send_event(REQ_FLASH_END, 8'h00, 1'b0);
        send_event(REQ_TICK, 8'h00, 1'b0);
        send_event(REQ_BOOT, 8'h00, 1'b1);
        send_event(REQ_BOOT, 8'hff, 1'b0);
        send_event(REQ_FLASH_BEGIN, 8'h00, 1'b0);
        send_event(REQ_FLASH_END, 8'h00, 1'b0);
        send_event(REQ_START, 8'h00, 1'b1);
        send_event(REQ_START, 8'h00, 1'b0);
        send_event(REQ_NOTE, 8'h00, 1'b0);
        send_event(REQ_NOTE, 8'h07, 1'b0);
        send_event(REQ_NOTE, 8'h08, 1'b1);
        send_event(REQ_FEED, 8'hff, 1'b0);
        send_event(REQ_FEED, 8'h01, 1'b1);
        send_event(REQ_FLASH_BEGIN, 8'h00, 1'b0);
        send_event(REQ_NOTE, 8'h04, 1'b0);
        send_event(REQ_FEED, 8'h04, 1'b0);
        send_event(REQ_FLASH_END, 8'h00, 1'b0);

        set_registers(1, 1, 2, 1, 1, 1);
        run_random(90);

        set_registers(16000, 16000, 255, 254, 254, 254);
        run_random(50);
        deep_nesting();

        for (int p = 0; p < 5; p++)
        begin
            set_registers($urandom_range(1, 12), $urandom_range(1, 8),
                          rbit() ? $urandom_range(2, 20) : $urandom_range(2, 255),
                          $urandom_range(1, 254),
                          rbit() ? $urandom_range(1, 10) : $urandom_range(1, 254),
                          rbit() ? $urandom_range(1, 10) : $urandom_range(1, 254));
            quiet = (p == 1);
            run_random(70);
        end
        quiet = 1'b0;

        settle();
        $display("Sent %0d event words (%0d changed state) under %0d register settings.",
                 tracker.events, tracker.effective, settings);
        $display("Checked %0d status words, %0d expiries, lease depth peaked at %0d.",
                 tracker.checked, tracker.expiries, tracker.peak_depth);
        if (tracker.fails == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/nlw_pkg.sv
hdl/nlw_engine.sv
hdl/nlw_outbuf.sv
hdl/nested_lease_watchdog_core.sv
hdl/nlw_chk.sv
tb/tb_nested_lease_watchdog_core.sv
